// ===== rtl/pic_pkg.sv =====
// Package for the PE image checksum block: result type, constants and the
// 16-bit end-around carry fold. No dependencies.
`default_nettype none

package pic_pkg;

    localparam int unsigned SumWidth   = 16;
    localparam int unsigned CountWidth = 32;
    localparam int unsigned ByteWidth  = 8;

    localparam logic [CountWidth-1:0] CountMax   = {CountWidth{1'b1}};
    localparam logic [CountWidth:0]   FieldStep  = (CountWidth+1)'(2);

    typedef struct packed {
        logic [CountWidth-1:0] image_checksum;
        logic                  size_overflow;
    } t_result;

    // Fold a 17-bit sum back into 16 bits. A single fold is enough because
    // both addends are at most 16 bits wide.
    function automatic logic [SumWidth-1:0] fold16(input logic [SumWidth:0] s);
        logic [SumWidth:0] t;
        t = {1'b0, s[SumWidth-1:0]} + {{SumWidth{1'b0}}, s[SumWidth]};
        return t[SumWidth-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/pic_accum.sv =====
// Running word sum, held low byte and byte count of the PE image checksum.
// Depends on pic_pkg.
`default_nettype none

module pic_accum (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [pic_pkg::CountWidth-1:0] i_cfg_wdata,
    input  wire logic                          i_accept,
    input  wire logic [pic_pkg::ByteWidth-1:0] i_data_byte,
    input  wire logic                          i_last_byte,
    output pic_pkg::t_result                   o_result
);
    import pic_pkg::*;

    logic [CountWidth-1:0] r_skip_offset;
    logic [SumWidth-1:0]   r_running_sum, n_running_sum;
    logic [ByteWidth-1:0]  r_held_low, n_held_low;
    logic [CountWidth-1:0] r_byte_count, n_byte_count;
    logic                  r_saturated, n_saturated;

    logic [CountWidth-1:0] word_start;
    logic                  skip_word;
    logic [SumWidth-1:0]   sum_low, sum_word;

    // The word start is compared with offset + 2 at 33 bits, so an offset at
    // the very top does not wrap onto the word at position zero.
    assign word_start = {r_byte_count[CountWidth-1:1], 1'b0};
    assign skip_word  = (word_start == r_skip_offset) ||
                        ({1'b0, word_start} == ({1'b0, r_skip_offset} + FieldStep));

    assign sum_low  = fold16({1'b0, r_running_sum} +
                             {{(SumWidth+1-ByteWidth){1'b0}}, i_data_byte});
    assign sum_word = fold16({1'b0, r_running_sum} + {1'b0, i_data_byte, r_held_low});

    always_comb begin
        n_running_sum = r_running_sum;
        n_held_low    = r_held_low;
        n_byte_count  = r_byte_count;
        n_saturated   = r_saturated;
        if (!r_saturated) begin
            if (r_byte_count[0]) begin
                if (!skip_word) begin
                    n_running_sum = sum_word;
                end
            end else begin
                n_held_low = i_data_byte;
                if (i_last_byte) begin
                    n_running_sum = sum_low;
                end
            end
            if (r_byte_count == CountMax) begin
                n_saturated = 1'b1;
            end else begin
                n_byte_count = r_byte_count + CountWidth'(1);
            end
        end
    end

    assign o_result.image_checksum = {{(CountWidth-SumWidth){1'b0}}, n_running_sum}
                                     + n_byte_count;
    assign o_result.size_overflow  = n_saturated;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skip_offset <= '0;
        end else if (i_cfg_we) begin
            r_skip_offset <= i_cfg_wdata;
        end
    end

    // Every image starts from zero state once its last byte is accepted.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running_sum <= '0;
            r_held_low    <= '0;
            r_byte_count  <= '0;
            r_saturated   <= 1'b0;
        end else if (i_accept) begin
            if (i_last_byte) begin
                r_running_sum <= '0;
                r_held_low    <= '0;
                r_byte_count  <= '0;
                r_saturated   <= 1'b0;
            end else begin
                r_running_sum <= n_running_sum;
                r_held_low    <= n_held_low;
                r_byte_count  <= n_byte_count;
                r_saturated   <= n_saturated;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/pic_out_reg.sv =====
// Result register of the PE image checksum block with its valid flag.
// Depends on pic_pkg.
`default_nettype none

module pic_out_reg (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_load,
    input  wire pic_pkg::t_result i_result,
    input  wire logic             i_ready,
    output logic                  o_valid,
    output pic_pkg::t_result      o_result
);
    import pic_pkg::*;

    logic    r_valid, n_valid;
    t_result r_result;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

`default_nettype wire

// ===== rtl/pe_image_checksum.sv =====
// PE image checksum: one byte word per cycle, result on the last byte.
// The result word is registered and valid in the cycle after its last byte is accepted.
// Throughput: one byte per cycle when not stalled; the 16-bit add and fold paths set it.
// Input stalls only while a result is held and not taken.
// Reset (synchronous, active low) clears the sum, count, offset and output valid.
`default_nettype none

module pe_image_checksum (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [31:0] i_cfg_wdata,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_last_byte,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [31:0]      o_image_checksum,
    output logic             o_size_overflow
);
    import pic_pkg::*;

    logic    accept;
    t_result next_result;
    t_result held_result;

    assign o_ready = !o_valid || i_ready;
    assign accept  = i_valid && o_ready;

    pic_accum u_accum (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_accept    (accept),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .o_result    (next_result)
    );

    pic_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (accept && i_last_byte),
        .i_result (next_result),
        .i_ready  (i_ready),
        .o_valid  (o_valid),
        .o_result (held_result)
    );

    assign o_image_checksum = held_result.image_checksum;
    assign o_size_overflow  = held_result.size_overflow;

endmodule

`default_nettype wire

// ===== rtl/pic_checker.sv =====
// Port-level assertions for pe_image_checksum and the bind that attaches them.
// Depends only on the top level's ports.
`default_nettype none

module pic_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        o_ready,
    input wire logic        i_last_byte,
    input wire logic        o_valid,
    input wire logic        i_ready,
    input wire logic [31:0] o_image_checksum,
    input wire logic        o_size_overflow
);

    // A held result word stays put until taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_image_checksum)
                                && $stable(o_size_overflow))
        else $error("result word changed while stalled");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    a_stall_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |-> !o_ready)
        else $error("input taken while result word is stuck");

    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && i_last_byte |=> o_valid)
        else $error("no result after last byte");

    a_no_extra_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && !(i_valid && o_ready && i_last_byte) |=> !o_valid)
        else $error("result word repeated");

endmodule

bind pe_image_checksum pic_checker u_pic_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_valid          (i_valid),
    .o_ready          (o_ready),
    .i_last_byte      (i_last_byte),
    .o_valid          (o_valid),
    .i_ready          (i_ready),
    .o_image_checksum (o_image_checksum),
    .o_size_overflow  (o_size_overflow)
);

`default_nettype wire
